### rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// Stable priority queue package
// Shared record, action and cell control types for the queue and its cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_CLEAR  = 2'd2
   } action_type;

   typedef struct packed {
      logic [15:0] key;
      logic [30:0] student_id;
      logic [15:0] course_code;
      logic [31:0] grade_bits;
   } record_type;

   typedef struct packed {
      logic       ins;
      logic       rem;
      record_type rec;
   } cell_ctrl_type;

endpackage

### rtl/core/spq_intf.sv
// ----------------------------------------------------------------------------
// Stable priority queue channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface spq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [15:0] key;
   logic [30:0] student_id;
   logic [15:0] course_code;
   logic [31:0] grade_bits;

   modport source (output valid, action, key, student_id, course_code, grade_bits,
                   input ready);
   modport sink   (input valid, action, key, student_id, course_code, grade_bits,
                   output ready);
endinterface

interface spq_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic [15:0] out_key;
   logic [30:0] out_student_id;
   logic [15:0] out_course_code;
   logic [31:0] out_grade_bits;

   modport source (output valid, ok, out_key, out_student_id, out_course_code,
                   out_grade_bits, input ready);
   modport sink   (input valid, ok, out_key, out_student_id, out_course_code,
                   out_grade_bits, output ready);
endinterface

### rtl/core/spq_cell.sv
// ----------------------------------------------------------------------------
// Stable priority queue cell
// One sorted slot: keeps its record, takes the new record, or shifts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_cell
   import spq_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          occ,
   input  record_type    left_rec,
   input  logic          left_ahead,
   input  record_type    right_rec,
   output record_type    rec,
   output logic          ahead
);

   record_type rec_ff;
   record_type rec_in;

   // A held record with a key not above the new key stays ahead of it.
   assign ahead = occ && (rec_ff.key <= ctrl.rec.key);
   assign rec   = rec_ff;

   always_comb begin
      rec_in = rec_ff;
      if (ctrl.ins) begin
         if (!ahead) begin
            rec_in = left_ahead ? ctrl.rec : left_rec;
         end
      end else if (ctrl.rem) begin
         rec_in = right_rec;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

endmodule

### rtl/core/stable_min_priority_queue.sv
// ----------------------------------------------------------------------------
// Stable minimum-key priority queue
// The response beat is valid in the cycle after the request beat.
// Throughput: one request per cycle while the response is not stalled; all cells update together.
// Reset empties the queue and drops any pending response beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stable_min_priority_queue
   import spq_pkg::*;
#(
   parameter int SLOTS = 16
)
(
   input logic        clock,
   input logic        reset,
   spq_req_if.sink    req_ch,
   spq_rsp_if.source  rsp_ch
);

   localparam int NCELL = SLOTS - 1;
   localparam int CNT_W = (SLOTS > 2) ? $clog2(SLOTS) : 1;
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(NCELL);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             valid_ff;
   logic             valid_in;
   logic             ok_ff;
   logic             ok_in;
   record_type       out_ff;
   record_type       out_in;

   logic             accept;
   logic             full;
   logic             empty;
   cell_ctrl_type    ctrl;
   record_type       new_rec;
   record_type       rec_chain [NCELL];
   logic             ahead_chain [NCELL];

   assign req_ch.ready = !valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign full         = (count_ff == FULL_CNT);
   assign empty        = (count_ff == '0);

   assign new_rec.key         = req_ch.key;
   assign new_rec.student_id  = req_ch.student_id;
   assign new_rec.course_code = req_ch.course_code;
   assign new_rec.grade_bits  = req_ch.grade_bits;

   assign ctrl.ins = accept && (req_ch.action == ACT_INSERT) && !full;
   assign ctrl.rem = accept && (req_ch.action == ACT_REMOVE) && !empty;
   assign ctrl.rec = new_rec;

   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      logic       occ;
      record_type left_rec;
      logic       left_ahead;
      record_type right_rec;

      assign occ = (count_ff > CNT_W'(i));

      if (i == 0) begin : g_head
         assign left_rec   = new_rec;
         assign left_ahead = 1'b1;
      end else begin : g_body
         assign left_rec   = rec_chain[i-1];
         assign left_ahead = ahead_chain[i-1];
      end

      if (i == NCELL - 1) begin : g_tail
         assign right_rec = '0;
      end else begin : g_inner
         assign right_rec = rec_chain[i+1];
      end

      spq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occ        (occ),
         .left_rec   (left_rec),
         .left_ahead (left_ahead),
         .right_rec  (right_rec),
         .rec        (rec_chain[i]),
         .ahead      (ahead_chain[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      valid_in = valid_ff;
      ok_in    = ok_ff;
      out_in   = out_ff;
      if (rsp_ch.valid && rsp_ch.ready) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in = 1'b1;
         ok_in    = 1'b0;
         out_in   = '0;
         case (req_ch.action)
            ACT_INSERT: begin
               if (!full) begin
                  ok_in    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            ACT_REMOVE: begin
               if (!empty) begin
                  ok_in    = 1'b1;
                  out_in   = rec_chain[0];
                  count_in = count_ff - 1'b1;
               end
            end
            ACT_CLEAR: begin
               if (!empty) begin
                  ok_in    = 1'b1;
                  count_in = '0;
               end
            end
            default: begin
               ok_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
         ok_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= valid_in;
         ok_ff    <= ok_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_ch.valid           = valid_ff;
   assign rsp_ch.ok              = ok_ff;
   assign rsp_ch.out_key         = out_ff.key;
   assign rsp_ch.out_student_id  = out_ff.student_id;
   assign rsp_ch.out_course_code = out_ff.course_code;
   assign rsp_ch.out_grade_bits  = out_ff.grade_bits;

endmodule
